// ----- rtl/rvdec_pkg.sv -----
// Package for the RV32I instruction decoder: opcodes, class and operation codes,
// the result record and the combinational decode functions.
// No dependencies; used by the channel interfaces and the top level.
package rvdec_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned LenWidth   = 5;
  localparam int unsigned OpWidth    = 5;
  localparam int unsigned RegWidth   = 5;

  // Major opcodes (bits 6:0).
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MUL  = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SRL = 3'd5;

  localparam logic [OpWidth-1:0] OP_SUB = 5'd8;
  localparam logic [OpWidth-1:0] OP_SRA = 5'd9;
  localparam logic [OpWidth-1:0] OP_MUL = 5'd10;

  localparam logic [LenWidth-1:0] LEN_16  = 5'd2;
  localparam logic [LenWidth-1:0] LEN_32  = 5'd4;
  localparam logic [LenWidth-1:0] LEN_48  = 5'd6;
  localparam logic [LenWidth-1:0] LEN_64  = 5'd8;
  localparam logic [LenWidth-1:0] LEN_80  = 5'd10;
  localparam logic [LenWidth-1:0] LEN_192 = 5'd24;

  typedef enum logic [3:0] {
    CL_ALU_REG = 4'd0,
    CL_ALU_IMM = 4'd1,
    CL_LOAD    = 4'd2,
    CL_STORE   = 4'd3,
    CL_BRANCH  = 4'd4,
    CL_JAL     = 4'd5,
    CL_JALR    = 4'd6,
    CL_LUI     = 4'd7,
    CL_AUIPC   = 4'd8,
    CL_ECALL   = 4'd9,
    CL_EBREAK  = 4'd10,
    CL_UNKNOWN = 4'd11
  } instr_class_e;

  typedef struct packed {
    logic [LenWidth-1:0]        length_bytes;
    logic                       is_32bit;
    logic                       valid_res;
    instr_class_e               instr_class;
    logic [OpWidth-1:0]         operation;
    logic [RegWidth-1:0]        dest_reg;
    logic [RegWidth-1:0]        src1_reg;
    logic [RegWidth-1:0]        src2_reg;
    logic signed [InstrWidth-1:0] immediate;
  } rvdec_result_t;

  function automatic logic [LenWidth-1:0] length_of(logic [InstrWidth-1:0] w);
    logic [LenWidth-1:0] len;
    if (w[1:0] != 2'b11) begin
      len = LEN_16;
    end else if (w[4:2] != 3'b111) begin
      len = LEN_32;
    end else if (!w[5]) begin
      len = LEN_48;
    end else if (!w[6]) begin
      len = LEN_64;
    end else if (w[14:12] != 3'b111) begin
      len = LEN_80 + {1'b0, w[14:12], 1'b0};
    end else begin
      len = LEN_192;
    end
    return len;
  endfunction

  function automatic logic [InstrWidth-1:0] imm_i(logic [InstrWidth-1:0] w);
    return {{20{w[31]}}, w[31:20]};
  endfunction

  function automatic logic [InstrWidth-1:0] imm_s(logic [InstrWidth-1:0] w);
    return {{20{w[31]}}, w[31:25], w[11:7]};
  endfunction

  function automatic logic [InstrWidth-1:0] imm_b(logic [InstrWidth-1:0] w);
    return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  endfunction

  function automatic logic [InstrWidth-1:0] imm_j(logic [InstrWidth-1:0] w);
    return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  endfunction

  function automatic logic [InstrWidth-1:0] imm_u(logic [InstrWidth-1:0] w);
    return {{12{w[31]}}, w[31:12]};
  endfunction

  function automatic rvdec_result_t decode_word(logic [InstrWidth-1:0] w, logic mul_en);
    rvdec_result_t r;
    logic [6:0]    opc;
    logic [2:0]    f3;
    logic [6:0]    f7;
    opc = w[6:0];
    f3  = w[14:12];
    f7  = w[31:25];

    r.length_bytes = length_of(w);
    r.is_32bit     = (r.length_bytes == LEN_32);
    r.valid_res    = 1'b0;
    r.instr_class  = CL_UNKNOWN;
    r.operation    = '0;
    r.dest_reg     = '0;
    r.src1_reg     = '0;
    r.src2_reg     = '0;
    r.immediate    = '0;

    if (r.is_32bit) begin
      r.dest_reg = w[11:7];
      r.src1_reg = w[19:15];
      r.src2_reg = w[24:20];
      case (opc)
        OPC_OP: begin
          r.instr_class = CL_ALU_REG;
          r.operation   = {2'b00, f3};
          if (mul_en && f7 == F7_MUL) begin
            r.operation = OP_MUL + {2'b00, f3};
            r.valid_res = 1'b1;
          end else if (f7 == F7_ALT && f3 == F3_ADD) begin
            r.operation = OP_SUB;
            r.valid_res = 1'b1;
          end else if (f7 == F7_ALT && f3 == F3_SRL) begin
            r.operation = OP_SRA;
            r.valid_res = 1'b1;
          end else if (f7 == F7_BASE) begin
            r.valid_res = 1'b1;
          end
        end
        OPC_OP_IMM: begin
          r.instr_class = CL_ALU_IMM;
          r.operation   = {2'b00, f3};
          if (f3 == F3_SLL || f3 == F3_SRL) begin
            // Shifts carry the shift amount rather than an I-immediate.
            r.immediate = {27'd0, w[24:20]};
            if (f7 == F7_BASE) begin
              r.valid_res = 1'b1;
            end else if (f3 == F3_SRL && f7 == F7_ALT) begin
              r.operation = OP_SRA;
              r.valid_res = 1'b1;
            end
          end else begin
            r.immediate = imm_i(w);
            r.valid_res = 1'b1;
          end
        end
        OPC_LOAD: begin
          r.instr_class = CL_LOAD;
          r.operation   = {2'b00, f3};
          r.immediate   = imm_i(w);
          r.valid_res   = f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5};
        end
        OPC_STORE: begin
          r.instr_class = CL_STORE;
          r.operation   = {2'b00, f3};
          r.immediate   = imm_s(w);
          r.valid_res   = f3 inside {[3'd0:3'd2]};
        end
        OPC_BRANCH: begin
          r.instr_class = CL_BRANCH;
          r.operation   = {2'b00, f3};
          r.immediate   = imm_b(w);
          r.valid_res   = !(f3 inside {3'd2, 3'd3});
        end
        OPC_JAL: begin
          r.instr_class = CL_JAL;
          r.immediate   = imm_j(w);
          r.valid_res   = 1'b1;
        end
        OPC_LUI: begin
          r.instr_class = CL_LUI;
          r.immediate   = imm_u(w);
          r.valid_res   = 1'b1;
        end
        OPC_AUIPC: begin
          r.instr_class = CL_AUIPC;
          r.immediate   = imm_u(w);
          r.valid_res   = 1'b1;
        end
        OPC_JALR: begin
          if (f3 == F3_ADD) begin
            r.instr_class = CL_JALR;
            r.immediate   = imm_i(w);
            r.valid_res   = 1'b1;
          end
        end
        OPC_SYSTEM: begin
          if (f3 == F3_ADD && w[31:20] == 12'd0) begin
            r.instr_class = CL_ECALL;
            r.valid_res   = 1'b1;
          end else if (f3 == F3_ADD && w[31:20] == 12'd1) begin
            r.instr_class = CL_EBREAK;
            r.immediate   = 32'sd1;
            r.valid_res   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ----- rtl/rvdec_in_if.sv -----
// Instruction channel: valid/ready handshake carrying one raw instruction word.
// Depends on rvdec_pkg for the word width.
interface rvdec_in_if;
  import rvdec_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [InstrWidth-1:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

// ----- rtl/rvdec_out_if.sv -----
// Decode result channel: valid/ready handshake carrying the decoded fields.
// Depends on rvdec_pkg for field widths and the class type.
interface rvdec_out_if;
  import rvdec_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [LenWidth-1:0]          length_bytes;
  logic                         is_32bit;
  logic                         valid_res;
  instr_class_e                 instr_class;
  logic [OpWidth-1:0]           operation;
  logic [RegWidth-1:0]          dest_reg;
  logic [RegWidth-1:0]          src1_reg;
  logic [RegWidth-1:0]          src2_reg;
  logic signed [InstrWidth-1:0] immediate;

  modport source (
    output valid, output length_bytes, output is_32bit, output valid_res,
    output instr_class, output operation, output dest_reg, output src1_reg,
    output src2_reg, output immediate, input ready
  );
  modport sink (
    input valid, input length_bytes, input is_32bit, input valid_res,
    input instr_class, input operation, input dest_reg, input src1_reg,
    input src2_reg, input immediate, output ready
  );
endinterface

// ----- rtl/rv32i_instruction_decoder_top.sv -----
// RV32I instruction decoder, top level.
// Depends on rvdec_pkg, rvdec_in_if and rvdec_out_if.
//
// Usage:
//   instr_i  carries one 32-bit instruction word per transaction (valid/ready).
//   result_o carries one decoded record per transaction: length in bytes,
//            32-bit flag, valid flag, class, operation, rd/rs1/rs2 and the
//            immediate, sign-extended but for the zero-extended shift amount.
//   cfg_we_i/cfg_wdata_i write the multiply/divide enable; change it only
//   while no word is in flight.
// A word accepted at a clock edge is captured in the input register, decoded
// in one pass and captured in the result register once that stage is free;
// the result then stays on result_o until its result transaction completes.
// Throughput is one word per cycle while the receiver does not stall, as each
// stage loads in the same cycle that its content moves on.
// While the receiver stalls, the result register holds its record and the
// input register keeps accepting until both stages are full; instr_i.ready
// then falls until result_o.ready returns.
// Reset empties both stages and clears the multiply/divide enable.
module rv32i_instruction_decoder_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  rvdec_in_if.sink    instr_i,
  rvdec_out_if.source result_o
);
  import rvdec_pkg::*;

  logic                  mul_en_q;
  logic                  in_vld_q,  in_vld_d;
  logic [InstrWidth-1:0] in_word_q;
  logic                  out_vld_q, out_vld_d;
  rvdec_result_t         res_q,     res_d;
  logic                  out_free;
  logic                  in_free;
  logic                  in_take;
  logic                  out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      mul_en_q <= cfg_wdata_i;
    end
  end

  // Each stage may load when it is empty or its content moves on this cycle.
  assign out_free = !out_vld_q || result_o.ready;
  assign in_free  = !in_vld_q || out_free;
  assign in_take  = instr_i.valid && in_free;
  assign out_load = in_vld_q && out_free;

  assign instr_i.ready = in_free;

  always_comb begin
    in_vld_d  = in_free ? instr_i.valid : in_vld_q;
    out_vld_d = out_free ? in_vld_q : out_vld_q;
    res_d     = decode_word(in_word_q, mul_en_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= instr_i.instr_word;
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.length_bytes = res_q.length_bytes;
  assign result_o.is_32bit     = res_q.is_32bit;
  assign result_o.valid_res    = res_q.valid_res;
  assign result_o.instr_class  = res_q.instr_class;
  assign result_o.operation    = res_q.operation;
  assign result_o.dest_reg     = res_q.dest_reg;
  assign result_o.src1_reg     = res_q.src1_reg;
  assign result_o.src2_reg     = res_q.src2_reg;
  assign result_o.immediate    = res_q.immediate;

endmodule

// ----- tb/tb_rv32i_instruction_decoder_top.sv -----
// Testbench for rv32i_instruction_decoder_top: drives instruction words over instr_i and checks
// every decoded record on result_o against a decoder model kept in the testbench.
// Depends on rvdec_pkg, rvdec_in_if, rvdec_out_if and the decoder top level.
module tb_rv32i_instruction_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rvdec_pkg::*;

  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 60;

  // funct3 and immediate codes that the package does not name.
  localparam logic [2:0]  LD_BYTE     = 3'd0;
  localparam logic [2:0]  LD_HALF     = 3'd1;
  localparam logic [2:0]  LD_WORD     = 3'd2;
  localparam logic [2:0]  LD_BYTE_U   = 3'd4;
  localparam logic [2:0]  LD_HALF_U   = 3'd5;
  localparam logic [2:0]  ST_WORD     = 3'd2;
  localparam logic [2:0]  BR_RSVD_LO  = 3'd2;
  localparam logic [2:0]  BR_RSVD_HI  = 3'd3;
  localparam logic [2:0]  F3_TOP      = 3'd7;
  localparam logic [11:0] SYS_ECALL   = 12'd0;
  localparam logic [11:0] SYS_EBREAK  = 12'd1;

  typedef struct {
    logic [31:0]   word;
    rvdec_result_t fields;
  } decoded_entry_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  rvdec_in_if  instr_if ();
  rvdec_out_if result_if ();

  rv32i_instruction_decoder_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .instr_i     (instr_if),
    .result_o    (result_if)
  );

  decoded_entry_t decoded_q [$];
  logic           mul_ext_shadow;
  int             error_count;
  int             send_idle_pct;
  int             stall_pct;
  int             hold_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else begin
        result_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic rvdec_result_t decode_expected(logic [31:0] w, logic mul_en);
    rvdec_result_t r;
    logic [2:0]    f3;
    logic [6:0]    f7;
    f3 = w[14:12];
    f7 = w[31:25];
    r = '0;
    r.instr_class = CL_UNKNOWN;
    if (w[1:0] != 2'b11) begin
      r.length_bytes = LEN_16;
    end else if (w[4:2] != 3'b111) begin
      r.length_bytes = LEN_32;
    end else if (!w[5]) begin
      r.length_bytes = LEN_48;
    end else if (!w[6]) begin
      r.length_bytes = LEN_64;
    end else if (f3 != F3_TOP) begin
      r.length_bytes = LEN_80 + {1'b0, f3, 1'b0};
    end else begin
      r.length_bytes = LEN_192;
    end
    if (r.length_bytes == LEN_32) begin
      r.is_32bit = 1'b1;
      r.dest_reg = w[11:7];
      r.src1_reg = w[19:15];
      r.src2_reg = w[24:20];
      case (w[6:0])
        OPC_OP: begin
          r.instr_class = CL_ALU_REG;
          r.operation = {2'b00, f3};
          if (mul_en && f7 == F7_MUL) begin
            r.operation = OP_MUL + {2'b00, f3};
            r.valid_res = 1'b1;
          end else if (f7 == F7_ALT && f3 == F3_ADD) begin
            r.operation = OP_SUB;
            r.valid_res = 1'b1;
          end else if (f7 == F7_ALT && f3 == F3_SRL) begin
            r.operation = OP_SRA;
            r.valid_res = 1'b1;
          end else if (f7 == F7_BASE) begin
            r.valid_res = 1'b1;
          end
        end
        OPC_OP_IMM: begin
          r.instr_class = CL_ALU_IMM;
          r.operation = {2'b00, f3};
          if (f3 == F3_SLL || f3 == F3_SRL) begin
            r.immediate = {27'd0, w[24:20]};
            if (f7 == F7_BASE) begin
              r.valid_res = 1'b1;
            end else if (f3 == F3_SRL && f7 == F7_ALT) begin
              r.operation = OP_SRA;
              r.valid_res = 1'b1;
            end
          end else begin
            r.immediate = 32'($signed(w[31:20]));
            r.valid_res = 1'b1;
          end
        end
        OPC_LOAD: begin
          r.instr_class = CL_LOAD;
          r.operation = {2'b00, f3};
          r.immediate = 32'($signed(w[31:20]));
          r.valid_res = (f3 == LD_BYTE || f3 == LD_HALF || f3 == LD_WORD ||
                         f3 == LD_BYTE_U || f3 == LD_HALF_U);
        end
        OPC_STORE: begin
          r.instr_class = CL_STORE;
          r.operation = {2'b00, f3};
          r.immediate = 32'($signed({w[31:25], w[11:7]}));
          r.valid_res = (f3 <= ST_WORD);
        end
        OPC_BRANCH: begin
          r.instr_class = CL_BRANCH;
          r.operation = {2'b00, f3};
          r.immediate = 32'($signed({w[31], w[7], w[30:25], w[11:8], 1'b0}));
          r.valid_res = (f3 != BR_RSVD_LO && f3 != BR_RSVD_HI);
        end
        OPC_JAL: begin
          r.instr_class = CL_JAL;
          r.immediate = 32'($signed({w[31], w[19:12], w[20], w[30:21], 1'b0}));
          r.valid_res = 1'b1;
        end
        OPC_LUI, OPC_AUIPC: begin
          r.instr_class = (w[6:0] == OPC_LUI) ? CL_LUI : CL_AUIPC;
          r.immediate = 32'($signed(w[31:12]));
          r.valid_res = 1'b1;
        end
        OPC_JALR: begin
          if (f3 == F3_ADD) begin
            r.instr_class = CL_JALR;
            r.immediate = 32'($signed(w[31:20]));
            r.valid_res = 1'b1;
          end
        end
        OPC_SYSTEM: begin
          if (f3 == F3_ADD && w[31:20] == SYS_ECALL) begin
            r.instr_class = CL_ECALL;
            r.valid_res = 1'b1;
          end else if (f3 == F3_ADD && w[31:20] == SYS_EBREAK) begin
            r.instr_class = CL_EBREAK;
            r.immediate = 32'sd1;
            r.valid_res = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  // Mostly well-formed 32-bit words with random content; the rest is plain noise,
  // which also covers the 16-bit and longer length encodings.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(99) < 85) begin
      case ($urandom_range(9))
        0: w[6:0] = OPC_OP;
        1: w[6:0] = OPC_OP_IMM;
        2: w[6:0] = OPC_LOAD;
        3: w[6:0] = OPC_STORE;
        4: w[6:0] = OPC_BRANCH;
        5: w[6:0] = OPC_JAL;
        6: w[6:0] = OPC_LUI;
        7: w[6:0] = OPC_AUIPC;
        8: w[6:0] = OPC_JALR;
        default: w[6:0] = OPC_SYSTEM;
      endcase
      case ($urandom_range(3))
        0: w[31:25] = F7_BASE;
        1: w[31:25] = F7_MUL;
        2: w[31:25] = F7_ALT;
        default: begin
        end
      endcase
      if ((w[6:0] == OPC_SYSTEM || w[6:0] == OPC_JALR) && $urandom_range(1) == 1) begin
        w[14:12] = F3_ADD;
        if (w[6:0] == OPC_SYSTEM) begin
          w[31:20] = $urandom_range(1) ? SYS_EBREAK : SYS_ECALL;
        end
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // One word per call; valid stays high after the transaction so that the next
  // call can follow back to back.
  task automatic send_word(logic [31:0] w);
    decoded_entry_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      instr_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    instr_if.valid      <= 1'b1;
    instr_if.instr_word <= w;
    do @(posedge clk_i); while (!instr_if.ready);
    entry.word   = w;
    entry.fields = decode_expected(w, mul_ext_shadow);
    decoded_q.push_back(entry);
  endtask

  task automatic drain_results();
    instr_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mul_ext(logic en);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mul_ext_shadow = en;
  endtask

  always @(posedge clk_i) begin
    decoded_entry_t e;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("decoded record arrived with no instruction word outstanding");
      end else begin
        e = decoded_q.pop_front();
        if (result_if.length_bytes !== e.fields.length_bytes)
          report_mismatch($sformatf("word %h length_bytes got %0d want %0d", e.word,
                                    result_if.length_bytes, e.fields.length_bytes));
        if (result_if.is_32bit !== e.fields.is_32bit)
          report_mismatch($sformatf("word %h is_32bit got %b want %b", e.word,
                                    result_if.is_32bit, e.fields.is_32bit));
        if (result_if.valid_res !== e.fields.valid_res)
          report_mismatch($sformatf("word %h valid_res got %b want %b", e.word,
                                    result_if.valid_res, e.fields.valid_res));
        if (result_if.instr_class !== e.fields.instr_class)
          report_mismatch($sformatf("word %h instr_class got %0d want %0d", e.word,
                                    result_if.instr_class, e.fields.instr_class));
        if (result_if.operation !== e.fields.operation)
          report_mismatch($sformatf("word %h operation got %0d want %0d", e.word,
                                    result_if.operation, e.fields.operation));
        if (result_if.dest_reg !== e.fields.dest_reg)
          report_mismatch($sformatf("word %h dest_reg got %0d want %0d", e.word,
                                    result_if.dest_reg, e.fields.dest_reg));
        if (result_if.src1_reg !== e.fields.src1_reg)
          report_mismatch($sformatf("word %h src1_reg got %0d want %0d", e.word,
                                    result_if.src1_reg, e.fields.src1_reg));
        if (result_if.src2_reg !== e.fields.src2_reg)
          report_mismatch($sformatf("word %h src2_reg got %0d want %0d", e.word,
                                    result_if.src2_reg, e.fields.src2_reg));
        if (result_if.immediate !== e.fields.immediate)
          report_mismatch($sformatf("word %h immediate got %h want %h", e.word,
                                    result_if.immediate, e.fields.immediate));
      end
    end
  end

  // Length encodings, every class and the malformed forms, with the extension off.
  task automatic test_directed();
    logic [31:0] words [0:26];
    words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_001F, 32'h0000_003F, 32'h0000_607F,
              32'h0031_00B3, 32'h4031_00B3, 32'h4031_D0B3, 32'h0231_00B3, 32'hFE00_70B3,
              32'hFFF0_0093, 32'h41F0_D093, 32'h0210_9093, 32'h8001_2083, 32'h0001_3083,
              32'hFE11_2FA3, 32'h0001_7023, 32'hFE00_0EE3, 32'h0000_2063, 32'h8000_00EF,
              32'hFFFF_F0B7, 32'h7FFF_F097, 32'h0000_80E7, 32'h0000_90E7, 32'h0000_0073,
              32'h0010_0073, 32'h0020_0073};
    send_idle_pct = 0;
    stall_pct     = 0;
    foreach (words[k]) send_word(words[k]);
    send_word(32'h0000_000B);
  endtask

  // All eight multiply/divide operations with the extension switched on.
  task automatic test_mul_ext();
    set_mul_ext(1'b1);
    for (int k = 0; k < 8; k++) begin
      send_word({F7_MUL, 5'($urandom()), 5'($urandom()), 3'(k), 5'($urandom()), OPC_OP});
    end
  endtask

  // The receiver holds off long enough for both stages to fill and instr_i to stall.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = HOLD_CYCLES;
    repeat (30) send_word(random_word());
    drain_results();
  endtask

  task automatic test_random_phase(int idle_pct, int busy_pct, logic en, int count);
    set_mul_ext(en);
    send_idle_pct = idle_pct;
    stall_pct     = busy_pct;
    repeat (count) send_word(random_word());
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = 1'b0;
    instr_if.valid      = 1'b0;
    instr_if.instr_word = '0;
    mul_ext_shadow      = 1'b0;
    error_count         = 0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    hold_left           = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_mul_ext();
    test_backpressure();
    test_random_phase(0, 0, 1'b0, 200);
    test_random_phase(83, 0, 1'b1, 200);
    test_random_phase(0, 83, 1'b0, 200);
    test_random_phase(6, 6, 1'b1, 200);
    drain_results();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- rv32i_instruction_decoder_top.f -----
rtl/rvdec_pkg.sv
rtl/rvdec_in_if.sv
rtl/rvdec_out_if.sv
rtl/rv32i_instruction_decoder_top.sv
tb/tb_rv32i_instruction_decoder_top.sv
